### sv/lpa_pkg.sv
// Package for the lease pool allocator: beat structs, table entry, codes.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package lpa_pkg;

	// operation codes
	localparam logic [1:0] OP_REQUEST = 2'd0;
	localparam logic [1:0] OP_COMMIT  = 2'd1;
	localparam logic [1:0] OP_FREE    = 2'd2;
	localparam logic [1:0] OP_TICK    = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFREE  = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	// register addresses
	localparam logic [2:0] ADDR_MIN_RANGE = 3'd0;
	localparam logic [2:0] ADDR_MAX_RANGE = 3'd4;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  slot;
		logic [47:0] client_mac;
		logic [23:0] lease_seconds;
	} lpa_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  position;
		logic [31:0] expiry;
	} lpa_rsp_t;

	// one slot of the table
	typedef struct packed {
		logic [31:0] expiry;
		logic [47:0] owner;
		logic        owner_valid;
	} lpa_entry_t;

	// context of the operation in flight, seen by the head
	typedef struct packed {
		logic [1:0]  op;
		logic [47:0] mac;
		logic [31:0] exp_new;
		logic [31:0] now;
		logic        slot_act;
	} lpa_ctx_t;

	// what the head saw on the slot passing through it
	typedef struct packed {
		logic owner_hit;
		logic is_free;
	} lpa_flags_t;

endpackage

### sv/lpa_cell.sv
// One cell of the slot ring: holds one table entry, loads its neighbor's.
// Depends on lpa_pkg.
`timescale 1ns / 1ps
module lpa_cell
	import lpa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  lpa_entry_t nxt,
	output lpa_entry_t cur
);

	logic [31:0] expiry_q;
	logic        valid_q;
	logic [47:0] owner_q;

	// control part of the entry: cleared on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expiry_q <= '0;
			valid_q  <= 1'b0;
		end else if (shift) begin
			expiry_q <= nxt.expiry;
			valid_q  <= nxt.owner_valid;
		end
	end

	// owner address: meaningful only with valid set
	always_ff @(posedge clk) begin
		if (shift) begin
			owner_q <= nxt.owner;
		end
	end

	assign cur = '{expiry: expiry_q, owner: owner_q, owner_valid: valid_q};

endmodule

### sv/lpa_head.sv
// Head of the ring: applies the current operation to the slot passing by.
// Depends on lpa_pkg.
`timescale 1ns / 1ps
module lpa_head
	import lpa_pkg::*;
(
	input  lpa_ctx_t   ctx,
	input  logic       at_slot,
	input  logic       in_act,
	input  lpa_entry_t cur,
	output lpa_entry_t upd,
	output lpa_flags_t flags
);

	always_comb begin
		upd             = cur;
		flags.owner_hit = cur.owner_valid && (cur.owner == ctx.mac);
		flags.is_free   = (cur.expiry == '0);
		unique case (ctx.op)
			OP_COMMIT: begin
				if (at_slot && ctx.slot_act) begin
					upd.expiry      = ctx.exp_new;
					upd.owner       = ctx.mac;
					upd.owner_valid = 1'b1;
				end
			end
			OP_FREE: begin
				if (at_slot && ctx.slot_act) begin
					upd.expiry = '0;
				end
			end
			OP_TICK: begin
				// sweep out leases that have run out
				if (in_act && (cur.expiry != '0) && (cur.expiry <= ctx.now)) begin
					upd.expiry = '0;
				end
			end
			default: begin
				upd = cur;
			end
		endcase
	end

endmodule

### sv/lease_pool_allocator_core.sv
// Lease pool allocator top: APB registers, sequencer, ring of slot cells.
// Depends on lpa_pkg, lpa_cell, lpa_head.
//
// channel  | direction | handshake          | payload
// req      | in        | req_valid/req_stall | lpa_req_t
// rsp      | out       | rsp_valid/rsp_stall | lpa_rsp_t
// apb      | in/out    | psel/penable/pready | paddr, pwdata, prdata
//
// Every operation rotates the whole ring once per beat.
// The rotation passes every slot through the head cell; one slot passes a cycle.
// Reset clears all expiries, owner valid bits and the clock; registers take defaults.
// A new beat is taken only once the previous result has entered rsp.
// A stalled rsp holds the block in its done state until the beat is taken.
`timescale 1ns / 1ps
module lease_pool_allocator_core
	import lpa_pkg::*;
#(
	parameter int SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  lpa_req_t    req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output lpa_rsp_t    rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = (IW + 1 > 9) ? IW + 1 : 9;
	localparam logic [LW-1:0] SLOTS_L = LW'(SLOTS);
	localparam logic [IW-1:0] LAST    = IW'(SLOTS - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DONE} state_t;

	state_t      state_q;
	logic [IW-1:0] cnt_q;
	logic [8:0]  min_q, max_q;
	logic [31:0] now_q;
	lpa_ctx_t    ctx_q;
	logic [7:0]  slot_q;
	logic        hit_q, freereq_q, low_found_q;
	logic [IW-1:0] low_q;
	logic        rsp_valid_q;
	lpa_rsp_t    rsp_q;

	// configuration registers
	logic [LW-1:0] lim, min_l, slot_l, t_l;
	logic          req_act;
	assign pready = 1'b1;
	assign lim    = ({{(LW-9){1'b0}}, max_q} < SLOTS_L) ? {{(LW-9){1'b0}}, max_q} : SLOTS_L;
	assign min_l  = {{(LW-9){1'b0}}, min_q};
	assign slot_l = {{(LW-8){1'b0}}, req.slot};
	assign t_l    = {{(LW-IW){1'b0}}, cnt_q};
	assign req_act = (slot_l >= min_l) && (slot_l < lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 9'd1;
			max_q <= 9'd256;
		end else if (psel && penable && pwrite) begin
			if (paddr == ADDR_MIN_RANGE) min_q <= pwdata[8:0];
			if (paddr == ADDR_MAX_RANGE) max_q <= pwdata[8:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_MIN_RANGE) prdata = {23'd0, min_q};
		if (paddr == ADDR_MAX_RANGE) prdata = {23'd0, max_q};
	end

	// ring of cells
	lpa_entry_t ent [SLOTS];
	lpa_entry_t upd;
	lpa_flags_t flags;
	logic       shift, at_slot, in_act;

	assign shift   = (state_q == ST_SWEEP);
	assign at_slot = (t_l == {{(LW-8){1'b0}}, slot_q});
	assign in_act  = (t_l >= min_l) && (t_l < lim);

	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		lpa_entry_t nxt;
		if (k == SLOTS - 1) begin : g_tail
			assign nxt = upd;
		end else begin : g_mid
			assign nxt = ent[k+1];
		end
		lpa_cell u_cell (
			.clk(clk), .arst_n(arst_n), .shift(shift), .nxt(nxt), .cur(ent[k])
		);
	end

	lpa_head u_head (
		.ctx(ctx_q), .at_slot(at_slot), .in_act(in_act), .cur(ent[0]),
		.upd(upd), .flags(flags)
	);

	// result of the finished sweep
	lpa_rsp_t res;
	always_comb begin
		res = '{status: ST_OK, position: 8'd0, expiry: 32'd0};
		unique case (ctx_q.op)
			OP_REQUEST: begin
				if (hit_q || freereq_q) begin
					res.position = slot_q;
				end else if (low_found_q) begin
					res.position = 8'(low_q);
				end else begin
					res.status = ST_NOFREE;
				end
			end
			OP_COMMIT, OP_FREE: begin
				res.position = slot_q;
				if (!ctx_q.slot_act) res.status = ST_REFUSED;
				else if (ctx_q.op == OP_COMMIT) res.expiry = ctx_q.exp_new;
			end
			default: begin
				res = '{status: ST_OK, position: 8'd0, expiry: 32'd0};
			end
		endcase
	end

	logic req_take, rsp_free;
	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			now_q       <= '0;
			rsp_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			freereq_q   <= 1'b0;
			low_found_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != ST_DONE) rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						state_q     <= ST_SWEEP;
						hit_q       <= 1'b0;
						freereq_q   <= 1'b0;
						low_found_q <= 1'b0;
						if (req.op == OP_TICK) now_q <= now_q + 32'd1;
					end
				end
				ST_SWEEP: begin
					if (ctx_q.op == OP_REQUEST) begin
						if (at_slot && ctx_q.slot_act && flags.owner_hit) hit_q <= 1'b1;
						if (at_slot && ctx_q.slot_act && slot_q != 8'd0 && flags.is_free)
							freereq_q <= 1'b1;
						if (in_act && flags.is_free && !low_found_q) low_found_q <= 1'b1;
					end
					if (cnt_q == LAST) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_take) begin
			slot_q       <= req.slot;
			ctx_q.op     <= req.op;
			ctx_q.mac    <= req.client_mac;
			ctx_q.exp_new <= now_q + {8'd0, req.lease_seconds} - 32'd1;
			ctx_q.now    <= now_q + 32'd1;
			ctx_q.slot_act <= req_act;
		end
		if (state_q == ST_SWEEP && in_act && flags.is_free && !low_found_q)
			low_q <= cnt_q;
		if (state_q == ST_DONE && rsp_free)
			rsp_q <= res;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_SWEEP |-> cnt_q == '0)
		else $error("ring counter not at rest outside a sweep");
	a_take_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q == ST_SWEEP)
		else $error("accepted beat did not start a sweep");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && rsp_free |=> rsp_valid && state_q == ST_IDLE)
		else $error("finished sweep did not post a result");

endmodule
